// ===== hdl/rowg_pkg.sv =====
// Package for the repeated Ormsby wavelet generator: widths, constants,
// register indexes and the CORDIC arctangent table.
// No dependencies.
`default_nettype none
package rowg_pkg;
	localparam int FREQ_W   = 24;
	localparam int TIME_W   = 32;
	localparam int RCNT_W   = 5;
	localparam int SCALE_W  = 24;
	localparam int AMP_W    = 32;
	localparam int MUL_W    = 36;
	localparam int DIV_W    = 64;
	localparam int CRD_W    = 34;
	localparam int SINE_W   = 31;
	localparam int CRD_STEPS = 30;
	localparam int ADDR_W   = 5;

	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [2:0] REG_FREQ_ONE    = 3'd0;
	localparam logic [2:0] REG_FREQ_TWO    = 3'd1;
	localparam logic [2:0] REG_FREQ_THREE  = 3'd2;
	localparam logic [2:0] REG_FREQ_FOUR   = 3'd3;
	localparam logic [2:0] REG_PEAK_PERIOD = 3'd4;
	localparam logic [2:0] REG_REPEAT_CNT  = 3'd5;
	localparam logic [2:0] REG_AMP_SCALE   = 3'd6;

	function automatic logic signed [CRD_W-1:0] atan_val(input logic [4:0] idx);
		logic signed [CRD_W-1:0] v;
		case (idx)
			5'd0:  v = 34'sh3243F6A8;
			5'd1:  v = 34'sh1DAC6705;
			5'd2:  v = 34'sh0FADBAFC;
			5'd3:  v = 34'sh07F56EA6;
			5'd4:  v = 34'sh03FEAB76;
			5'd5:  v = 34'sh01FFD55B;
			5'd6:  v = 34'sh00FFFAAA;
			5'd7:  v = 34'sh007FFF55;
			5'd8:  v = 34'sh003FFFEA;
			5'd9:  v = 34'sh001FFFFD;
			5'd10: v = 34'sh000FFFFF;
			5'd11: v = 34'sh0007FFFF;
			5'd12: v = 34'sh0003FFFF;
			5'd13: v = 34'sh0001FFFF;
			5'd14: v = 34'sh0000FFFF;
			5'd15: v = 34'sh00007FFF;
			5'd16: v = 34'sh00003FFF;
			5'd17: v = 34'sh00001FFF;
			5'd18: v = 34'sh00000FFF;
			5'd19: v = 34'sh000007FF;
			5'd20: v = 34'sh000003FF;
			5'd21: v = 34'sh000001FF;
			5'd22: v = 34'sh000000FF;
			5'd23: v = 34'sh0000007F;
			5'd24: v = 34'sh0000003F;
			5'd25: v = 34'sh0000001F;
			5'd26: v = 34'sh0000000F;
			5'd27: v = 34'sh00000008;
			5'd28: v = 34'sh00000004;
			5'd29: v = 34'sh00000002;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

// ===== hdl/rowg_mul.sv =====
// Shared signed multiplier with a registered, enabled product.
// Depends on rowg_pkg.
`default_nettype none
module rowg_mul (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [rowg_pkg::MUL_W-1:0] a,
	input  wire logic signed [rowg_pkg::MUL_W-1:0] b,
	output logic signed [2*rowg_pkg::MUL_W-1:0]    p
);
	logic signed [2*rowg_pkg::MUL_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

	assign p = p_q;
endmodule
`default_nettype wire

// ===== hdl/rowg_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rowg_pkg.
`default_nettype none
module rowg_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [rowg_pkg::DIV_W-1:0]  num,
	input  wire logic [rowg_pkg::DIV_W-1:0]  den,
	output logic                             busy,
	output logic                             done,
	output logic [rowg_pkg::DIV_W-1:0]       quo
);
	localparam int W = rowg_pkg::DIV_W;
	localparam int C_W = $clog2(W);

	logic [W:0]     rem_q;
	logic [W-1:0]   quo_q;
	logic [W-1:0]   den_q;
	logic [C_W-1:0] cnt_q;
	logic           run_q;
	logic           done_q;
	logic [W:0]     trial;

	assign trial = {rem_q[W-1:0], quo_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == C_W'(W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

// ===== hdl/rowg_cordic.sv =====
// Iterative rotation CORDIC sine, one micro-rotation per cycle.
// Depends on rowg_pkg.
`default_nettype none
module rowg_cordic (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [rowg_pkg::CRD_W-1:0] theta,
	output logic                                   busy,
	output logic                                   done,
	output logic [rowg_pkg::SINE_W-1:0]            sine
);
	localparam int W = rowg_pkg::CRD_W;

	logic signed [W-1:0] x_q, y_q, z_q;
	logic signed [W-1:0] dx, dy, at;
	logic [4:0]          i_q;
	logic                run_q;
	logic                done_q;

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = rowg_pkg::atan_val(i_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q   <= '0;
			end else if (run_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == 5'(rowg_pkg::CRD_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= rowg_pkg::CORDIC_GAIN;
			y_q <= '0;
			z_q <= theta;
		end else if (run_q) begin
			if (!z_q[W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	always_comb begin
		if (y_q[W-1]) begin
			sine = '0;
		end else if (y_q > 34'sd1073741824) begin
			sine = 31'd1073741824;
		end else begin
			sine = y_q[rowg_pkg::SINE_W-1:0];
		end
	end

	assign busy = run_q;
	assign done = done_q;
endmodule
`default_nettype wire

// ===== hdl/repeated_ormsby_wavelet_generator.sv =====
// Top level: register file, sequencer and shared multiplier, divider, CORDIC.
// Depends on rowg_pkg, rowg_mul, rowg_div, rowg_cordic.
//
// Usage: configure the corner frequencies, peak period, repeat count and
// amplitude scale over the APB port (pready is always high, writes take
// effect in the access cycle). Pulse start while busy is low with a
// sample_time; the item is taken at that edge and, but for the cases below, busy rises.
// When the sum is ready, done is high for exactly one cycle with amplitude
// and invalid valid; busy falls at the same edge. The receiver cannot stall.
// An equal frequency pair or a zero repeat count returns in the cycle after
// start. Otherwise each repetition runs, per corner frequency, the term,
// fold and theta steps, a CORDIC run, a division and the square and store
// steps (five single steps), then three divisions on the same divider and
// two accumulate steps. A corner whose time offset is zero or at least
// 2^32 skips the CORDIC and the division and takes only the term, square
// and store steps. One item is in flight at a time. Reset loads the
// register defaults and returns the sequencer to idle with no result pending.
`default_nettype none
module repeated_ormsby_wavelet_generator #(
	parameter int MAX_REPEATS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [rowg_pkg::ADDR_W-1:0]        paddr,
	input  wire logic [31:0]                        pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [rowg_pkg::TIME_W-1:0]        sample_time,
	output logic                                    done,
	output logic signed [rowg_pkg::AMP_W-1:0]       amplitude,
	output logic                                    invalid
);
	localparam int K_W   = $clog2(MAX_REPEATS + 1);
	localparam int T_W   = 34 + K_W;
	localparam int TOT_W = 37 + K_W;
	localparam int FW    = rowg_pkg::FREQ_W;
	localparam int MW    = rowg_pkg::MUL_W;
	localparam int DW    = rowg_pkg::DIV_W;

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_TERM  = 16'h0002,
		S_FOLD  = 16'h0004,
		S_THETA = 16'h0008,
		S_CORD  = 16'h0010,
		S_DIVQ  = 16'h0020,
		S_SQ    = 16'h0040,
		S_G     = 16'h0080,
		S_RHI   = 16'h0100,
		S_RHIW  = 16'h0200,
		S_RLO   = 16'h0400,
		S_RLOW  = 16'h0800,
		S_W     = 16'h1000,
		S_WW    = 16'h2000,
		S_SCALE = 16'h4000,
		S_ACC   = 16'h8000
	} state_t;

	state_t state_q;

	logic [FW-1:0]                     freq_q [0:3];
	logic [31:0]                       period_q;
	logic [rowg_pkg::RCNT_W-1:0]       rcnt_q;
	logic [rowg_pkg::SCALE_W-1:0]      scale_q;

	logic                              wr_en;
	logic [2:0]                        widx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign widx   = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q[0] <= 24'd256;
			freq_q[1] <= 24'd512;
			freq_q[2] <= 24'd1024;
			freq_q[3] <= 24'd2048;
			period_q  <= 32'd65536;
			rcnt_q    <= 5'd1;
			scale_q   <= 24'd65536;
		end else if (wr_en) begin
			case (widx)
				rowg_pkg::REG_FREQ_ONE:    freq_q[0] <= pwdata[FW-1:0];
				rowg_pkg::REG_FREQ_TWO:    freq_q[1] <= pwdata[FW-1:0];
				rowg_pkg::REG_FREQ_THREE:  freq_q[2] <= pwdata[FW-1:0];
				rowg_pkg::REG_FREQ_FOUR:   freq_q[3] <= pwdata[FW-1:0];
				rowg_pkg::REG_PEAK_PERIOD: period_q  <= pwdata;
				rowg_pkg::REG_REPEAT_CNT:  rcnt_q    <= pwdata[rowg_pkg::RCNT_W-1:0];
				rowg_pkg::REG_AMP_SCALE:   scale_q   <= pwdata[rowg_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			rowg_pkg::REG_FREQ_ONE:    prdata = {8'd0, freq_q[0]};
			rowg_pkg::REG_FREQ_TWO:    prdata = {8'd0, freq_q[1]};
			rowg_pkg::REG_FREQ_THREE:  prdata = {8'd0, freq_q[2]};
			rowg_pkg::REG_FREQ_FOUR:   prdata = {8'd0, freq_q[3]};
			rowg_pkg::REG_PEAK_PERIOD: prdata = period_q;
			rowg_pkg::REG_REPEAT_CNT:  prdata = {27'd0, rcnt_q};
			rowg_pkg::REG_AMP_SCALE:   prdata = {8'd0, scale_q};
			default:                   prdata = '0;
		endcase
	end

	logic signed [T_W-1:0]   tk_q;
	logic [K_W-1:0]          k_q, n_q;
	logic [1:0]              j_q;
	logic [31:0]             q_q;
	logic [47:0]             g_q [0:3];
	logic                    neg_q;
	logic signed [57:0]      rhi_q, rlo_q;
	logic signed [34:0]      w_q;
	logic signed [TOT_W-1:0] total_q;
	logic signed [31:0]      amp_q;
	logic                    inv_q;
	logic                    done_q;

	logic                     mul_en;
	logic signed [MW-1:0]     mul_a, mul_b;
	logic signed [2*MW-1:0]   mul_p;
	logic                     div_start, div_busy, div_done;
	logic [DW-1:0]            div_num, div_den, div_quo;
	logic                     crd_start, crd_busy, crd_done;
	logic signed [rowg_pkg::CRD_W-1:0] crd_theta;
	logic [rowg_pkg::SINE_W-1:0]       crd_sine;

	rowg_mul u_mul (
		.clk (clk), .en (mul_en), .a (mul_a), .b (mul_b), .p (mul_p)
	);

	rowg_div u_div (
		.clk (clk), .arst_n (arst_n), .start (div_start), .num (div_num),
		.den (div_den), .busy (div_busy), .done (div_done), .quo (div_quo)
	);

	rowg_cordic u_cordic (
		.clk (clk), .arst_n (arst_n), .start (crd_start), .theta (crd_theta),
		.busy (crd_busy), .done (crd_done), .sine (crd_sine)
	);

	logic [FW-1:0]            f_cur;
	logic [31:0]              cap;
	logic [T_W-1:0]           mag;
	logic                     t_zero, t_big;
	logic [24:0]              u_raw;
	logic [23:0]              u_fold;
	logic [25:0]              sum_f;
	logic                     bad_pair;
	logic [K_W-1:0]           n_next;
	logic signed [48:0]       dg;
	logic [47:0]              dg_mag;
	logic signed [24:0]       df;
	logic [23:0]              df_mag;
	logic                     pair_hi;
	logic signed [58:0]       rsum;
	logic signed [41:0]       rclip;
	logic [40:0]              r_mag;
	logic signed [63:0]       wv;
	logic signed [34:0]       wclip;
	logic signed [TOT_W-1:0]  total_next;
	logic signed [57:0]       r_div;
	logic                     last_rep;

	assign f_cur  = freq_q[j_q];
	assign cap    = {f_cur, 8'd0};
	assign mag    = tk_q[T_W-1] ? T_W'(-tk_q) : T_W'(tk_q);
	assign t_zero = (tk_q == '0);
	assign t_big  = |mag[T_W-1:32];
	assign u_raw  = {1'b0, mul_p[23:0]};
	assign u_fold = (u_raw > 25'h0800000) ? 24'(25'h1000000 - u_raw) : u_raw[23:0];
	assign sum_f  = 26'(freq_q[0]) + 26'(freq_q[1]) + 26'(freq_q[2]) + 26'(freq_q[3]);
	assign bad_pair = (freq_q[0] == freq_q[1]) || (freq_q[2] == freq_q[3]) ||
		(sum_f == '0);
	assign n_next = (32'(rcnt_q) > 32'(MAX_REPEATS)) ? K_W'(MAX_REPEATS) : K_W'(rcnt_q);

	assign pair_hi = (state_q == S_RHI);
	assign dg     = pair_hi ? ($signed({1'b0, g_q[3]}) - $signed({1'b0, g_q[2]}))
	                        : ($signed({1'b0, g_q[1]}) - $signed({1'b0, g_q[0]}));
	assign dg_mag = dg[48] ? 48'(-dg) : dg[47:0];
	assign df     = pair_hi ? ($signed({1'b0, freq_q[3]}) - $signed({1'b0, freq_q[2]}))
	                        : ($signed({1'b0, freq_q[1]}) - $signed({1'b0, freq_q[0]}));
	assign df_mag = df[24] ? 24'(-df) : df[23:0];

	assign rsum  = 59'(rhi_q) + 59'(rlo_q);
	assign rclip = (rsum > 59'sd1099511627776) ? 42'sd1099511627776 :
	               (rsum < -59'sd1099511627776) ? -42'sd1099511627776 : 42'(rsum);
	assign r_mag = rclip[41] ? 41'(-rclip) : rclip[40:0];

	assign r_div = neg_q ? -$signed({1'b0, div_quo[56:0]}) : $signed({1'b0, div_quo[56:0]});
	assign wv    = neg_q ? -$signed({1'b0, div_quo[62:0]}) : $signed({1'b0, div_quo[62:0]});
	assign wclip = (wv > 64'sd8589934592) ? 35'sd8589934592 :
	               (wv < -64'sd8589934592) ? -35'sd8589934592 : 35'(wv);

	assign total_next = total_q + $signed(mul_p[TOT_W+21:22]);
	assign last_rep   = ({1'b0, k_q} + 1'b1) == {1'b0, n_q};

	always_comb begin
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		crd_start = 1'b0;
		crd_theta = $signed({2'b00, mul_p[55:24]});
		case (state_q)
			S_TERM: begin
				mul_en = !t_zero && !t_big;
				mul_a  = $signed({12'd0, f_cur});
				mul_b  = $signed({12'd0, tk_q[23:0]});
			end
			S_FOLD: begin
				mul_en = 1'b1;
				mul_a  = $signed({12'd0, u_fold});
				mul_b  = $signed({4'd0, rowg_pkg::PI_Q30});
			end
			S_THETA: begin
				crd_start = 1'b1;
				mul_en    = 1'b1;
				mul_a     = $signed({4'd0, rowg_pkg::PI_Q30});
				mul_b     = $signed({4'd0, mag[31:0]});
			end
			S_CORD: begin
				div_start = crd_done;
				div_num   = {1'b0, crd_sine, 32'd0};
				div_den   = mul_p[63:0];
			end
			S_SQ: begin
				mul_en = 1'b1;
				mul_a  = $signed({4'd0, q_q});
				mul_b  = $signed({4'd0, q_q});
			end
			S_RHI, S_RLO: begin
				div_start = 1'b1;
				div_num   = {8'd0, dg_mag, 8'd0};
				div_den   = {40'd0, df_mag};
			end
			S_W: begin
				div_start = 1'b1;
				div_num   = {1'b0, r_mag, 22'd0};
				div_den   = {38'd0, sum_f};
			end
			S_SCALE: begin
				mul_en = 1'b1;
				mul_a  = MW'(w_q);
				mul_b  = MW'($signed(scale_q));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			k_q     <= '0;
			n_q     <= '0;
			j_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (bad_pair || n_next == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_TERM;
						end
						k_q <= '0;
						j_q <= '0;
						n_q <= n_next;
					end
				end
				S_TERM:  state_q <= (t_zero || t_big) ? S_SQ : S_FOLD;
				S_FOLD:  state_q <= S_THETA;
				S_THETA: state_q <= S_CORD;
				S_CORD:  if (crd_done) state_q <= S_DIVQ;
				S_DIVQ:  if (div_done) state_q <= S_SQ;
				S_SQ:    state_q <= S_G;
				S_G: begin
					j_q     <= j_q + 1'b1;
					state_q <= (j_q == 2'd3) ? S_RHI : S_TERM;
				end
				S_RHI:   state_q <= S_RHIW;
				S_RHIW:  if (div_done) state_q <= S_RLO;
				S_RLO:   state_q <= S_RLOW;
				S_RLOW:  if (div_done) state_q <= S_W;
				S_W:     state_q <= S_WW;
				S_WW:    if (div_done) state_q <= S_SCALE;
				S_SCALE: state_q <= S_ACC;
				S_ACC: begin
					if (last_rep) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						k_q     <= k_q + 1'b1;
						j_q     <= '0;
						state_q <= S_TERM;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				tk_q    <= $signed(T_W'(sample_time)) - $signed(T_W'(period_q));
				total_q <= '0;
				amp_q   <= '0;
				inv_q   <= bad_pair;
			end
			S_TERM:  q_q <= t_zero ? cap : 32'd0;
			S_DIVQ: begin
				if (div_done) begin
					q_q <= (div_quo > {32'd0, cap}) ? cap : div_quo[31:0];
				end
			end
			S_G:     g_q[j_q] <= mul_p[63:16];
			S_RHI, S_RLO: neg_q <= dg[48] ^ df[24];
			S_RHIW:  if (div_done) rhi_q <= r_div;
			S_RLOW:  if (div_done) rlo_q <= r_div;
			S_W:     neg_q <= rclip[41];
			S_WW:    if (div_done) w_q <= wclip;
			S_ACC: begin
				total_q <= total_next;
				tk_q    <= tk_q - $signed(T_W'(period_q));
				if (total_next > TOT_W'(32'sh7FFFFFFF)) begin
					amp_q <= 32'sh7FFFFFFF;
				end else if (total_next < -TOT_W'(64'sh80000000)) begin
					amp_q <= 32'sh80000000;
				end else begin
					amp_q <= total_next[31:0];
				end
			end
			default: ;
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign amplitude = amp_q;
	assign invalid   = inv_q;

	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result beat");
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && invalid) |-> (amplitude == '0))
		else $error("invalid beat with nonzero amplitude");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while running");
	a_crd_free: assert property (@(posedge clk) disable iff (!arst_n)
		crd_start |-> !crd_busy)
		else $error("CORDIC restarted while running");
endmodule
`default_nettype wire
